### rtl/aabb_pkg.sv
`default_nettype none

package aabb_pkg;

   // operation codes of the request transaction
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // field widths
   localparam int COORD_W = 16;
   localparam int IDX_W   = 6;
   localparam int BOX_W   = 4 * COORD_W;

   // one stored box, as kept in the table memory
   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_z;
      logic        [COORD_W-1:0] size_x;
      logic        [COORD_W-1:0] size_z;
   } box_type;

endpackage

`default_nettype wire

### rtl/aabb_if.sv
`default_nettype none

// request channel: add or query a box
interface aabb_req_if;
   logic               valid;
   logic               ready;
   logic               operation;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_z;
   logic        [15:0] size_x;
   logic        [15:0] size_z;

   modport source (
      output valid, operation, pos_x, pos_z, size_x, size_z,
      input  ready
   );
   modport sink (
      input  valid, operation, pos_x, pos_z, size_x, size_z,
      output ready
   );
endinterface

// response channel: one transaction per request
interface aabb_rsp_if;
   logic       valid;
   logic       ready;
   logic       hit;
   logic [5:0] hit_index;
   logic       table_full;

   modport source (
      output valid, hit, hit_index, table_full,
      input  ready
   );
   modport sink (
      input  valid, hit, hit_index, table_full,
      output ready
   );
endinterface

`default_nettype wire

### rtl/aabb_ram.sv
`default_nettype none

module aabb_ram #(
   parameter  int WIDTH  = 64,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output      logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/aabb_overlap_unit.sv
`default_nettype none

module aabb_overlap_unit import aabb_pkg::*; (
   input  wire box_type query,
   input  wire box_type entry,
   output      logic    overlap
);

   // inclusive test on one axis: |2*(cb - ca)| <= sa + sb
   function automatic logic axis_hit(
      input logic signed [COORD_W-1:0] ca,
      input logic        [COORD_W-1:0] sa,
      input logic signed [COORD_W-1:0] cb,
      input logic        [COORD_W-1:0] sb
   );
      logic signed [COORD_W:0]   diff;
      logic        [COORD_W:0]   mag;
      logic        [COORD_W+1:0] dist2;
      logic        [COORD_W+1:0] size_sum;
      begin
         diff     = (COORD_W+1)'(cb) - (COORD_W+1)'(ca);
         mag      = diff[COORD_W] ? (COORD_W+1)'(-diff) : (COORD_W+1)'(diff);
         dist2    = {mag, 1'b0};
         size_sum = (COORD_W+2)'(sa) + (COORD_W+2)'(sb);
         axis_hit = (dist2 <= size_sum);
      end
   endfunction

   // both axes must overlap
   assign overlap = axis_hit(query.pos_x, query.size_x, entry.pos_x, entry.size_x) &&
                    axis_hit(query.pos_z, query.size_z, entry.pos_z, entry.size_z);

endmodule

`default_nettype wire

### rtl/aabb_overlap_query_table.sv
// an add goes straight from acceptance to the response stage, with no scan of the table
// a query scans the N stored boxes (none if the table is empty), one table memory read per cycle
// one transaction at a time, ready only while idle
// reset (synchronous): box count cleared, sequencer idle, no response pending
// the table memory holds no reset value; entries are compared only after they are written
`default_nettype none

module aabb_overlap_query_table import aabb_pkg::*; #(
   parameter int MAX_BOXES = 64
) (
   input wire logic    clock,
   input wire logic    reset,
   aabb_req_if.sink    req_port,
   aabb_rsp_if.source  rsp_port
);

   localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CW = $clog2(MAX_BOXES + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]       state_ff,     state_in;
   logic [CW-1:0]    count_ff,     count_in;
   logic [AW-1:0]    chk_idx_ff,   chk_idx_in;
   box_type          query_ff,     query_in;
   logic             res_hit_ff,   res_hit_in;
   logic [IDX_W-1:0] res_idx_ff,   res_idx_in;
   logic             res_full_ff,  res_full_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff,   rsp_hit_in;
   logic [IDX_W-1:0] rsp_idx_ff,   rsp_idx_in;
   logic             rsp_full_ff,  rsp_full_in;

   box_type          req_box;
   logic             accept;
   logic             has_room;
   logic             last_entry;
   logic             ovl;
   logic             ram_wr_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [BOX_W-1:0] ram_rd_data;

   // request payload as a box
   assign req_box.pos_x  = req_port.pos_x;
   assign req_box.pos_z  = req_port.pos_z;
   assign req_box.size_x = req_port.size_x;
   assign req_box.size_z = req_port.size_z;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign accept         = req_port.valid && req_port.ready;
   assign has_room       = (count_ff < CW'(MAX_BOXES));
   assign last_entry     = ((CW'(chk_idx_ff) + CW'(1)) == count_ff);

   // table memory: append on add while the table has room, sequential read during scan
   assign ram_wr_en   = accept && (req_port.operation == OP_ADD) && has_room;
   assign ram_rd_addr = (state_ff == ST_SCAN) ? (chk_idx_ff + AW'(1)) : '0;

   aabb_ram #(
      .WIDTH (BOX_W),
      .DEPTH (MAX_BOXES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_box),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared overlap compare, one stored entry per cycle
   aabb_overlap_unit u_ovl (
      .query   (query_ff),
      .entry   (box_type'(ram_rd_data)),
      .overlap (ovl)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      chk_idx_in   = chk_idx_ff;
      query_in     = query_ff;
      res_hit_in   = res_hit_ff;
      res_idx_in   = res_idx_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_full_in  = rsp_full_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               query_in   = req_box;
               res_hit_in = 1'b0;
               res_idx_in = '0;
               chk_idx_in = '0;
               if (req_port.operation == OP_ADD) begin
                  res_full_in = !has_room;
                  if (has_room) begin
                     count_in = count_ff + CW'(1);
                  end
                  state_in = ST_DONE;
               end else begin
                  res_full_in = 1'b0;
                  state_in    = (count_ff == '0) ? ST_DONE : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // later hits overwrite earlier ones, keeping the highest index
            if (ovl) begin
               res_hit_in = 1'b1;
               res_idx_in = IDX_W'(chk_idx_ff);
            end
            if (last_entry) begin
               state_in = ST_DONE;
            end else begin
               chk_idx_in = chk_idx_ff + AW'(1);
            end
         end
         ST_DONE: begin
            // move the result into the output register once it is free
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_idx_in   = res_idx_ff;
               rsp_full_in  = res_full_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chk_idx_ff  <= chk_idx_in;
      query_ff    <= query_in;
      res_hit_ff  <= res_hit_in;
      res_idx_ff  <= res_idx_in;
      res_full_ff <= res_full_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.hit        = rsp_hit_ff;
   assign rsp_port.hit_index  = rsp_idx_ff;
   assign rsp_port.table_full = rsp_full_ff;

endmodule

`default_nettype wire
